>>> design/dcc_pkg.sv
// types and constants shared by the dcc packet framer
package dcc_pkg;

   localparam int PREAMBLE_LEN = 22;
   localparam int SLOT_COUNT   = 5;
   localparam int SLOT_BITS    = 9;
   localparam int TAIL_LEN     = 5;
   localparam int STREAM_BITS  = PREAMBLE_LEN + SLOT_COUNT * SLOT_BITS + TAIL_LEN;
   localparam int MAX_BYTES    = STREAM_BITS / 8;

   typedef logic [1:0] kind_type;

   localparam kind_type KIND_IDLE     = 2'd0;
   localparam kind_type KIND_FUNC_ONE = 2'd1;
   localparam kind_type KIND_THROTTLE = 2'd2;

   localparam logic [7:0] BYTE_IDLE_ADDR  = 8'hFF;
   localparam logic [7:0] BYTE_IDLE_DATA  = 8'h00;
   localparam logic [1:0] LONG_ADDR_TAG   = 2'b11;
   localparam logic [7:0] OP_SPEED_128    = 8'h3F;
   localparam logic [2:0] OP_FUNC_ONE_TAG = 3'b100;
   localparam logic [7:0] SPEED_ESTOP     = 8'h01;
   localparam logic [6:0] SPEED_MAX       = 7'd126;
   localparam logic [6:0] SPEED_OVER      = 7'd127;
   localparam logic [13:0] SHORT_ADDR_MAX = 14'd127;

   typedef struct packed {
      kind_type    kind;
      logic [13:0] loco_address;
      logic [6:0]  speed_step;
      logic        forward;
      logic        emergency_stop;
      logic [4:0]  function_bits;
   } req_type;

   typedef struct packed {
      logic [STREAM_BITS-1:0] bits;
      logic [3:0]             nbytes;
   } frame_type;

endpackage

>>> design/dcc_if.sv
// request and response channel interfaces of the dcc packet framer
interface dcc_req_if;
   import dcc_pkg::*;
   logic        valid;
   logic        ready;
   kind_type    kind;
   logic [13:0] loco_address;
   logic [6:0]  speed_step;
   logic        forward;
   logic        emergency_stop;
   logic [4:0]  function_bits;

   modport source (output valid, kind, loco_address, speed_step, forward,
                   emergency_stop, function_bits, input ready);
   modport sink   (input valid, kind, loco_address, speed_step, forward,
                   emergency_stop, function_bits, output ready);
endinterface

interface dcc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] packet_byte;
   logic       last_byte;

   modport source (output valid, packet_byte, last_byte, input ready);
   modport sink   (input valid, packet_byte, last_byte, output ready);
endinterface

>>> design/dcc_frame_build.sv
// builds the full packed bitstream of one dcc command
module dcc_frame_build (
   input  dcc_pkg::req_type   cmd_i,
   output dcc_pkg::frame_type frame_o
);
   import dcc_pkg::*;

   logic       long_addr;
   logic [7:0] addr_hi;
   logic [7:0] addr_lo;
   logic [6:0] speed_sat;
   logic [7:0] speed_code;
   logic [7:0] func_op;
   logic [7:0] cmd_byte [SLOT_COUNT];
   logic [2:0] cmd_count;
   logic [7:0] check;
   logic [SLOT_BITS-1:0] slot [SLOT_COUNT];

   always_comb begin
      long_addr = cmd_i.loco_address > SHORT_ADDR_MAX;
      addr_hi   = {LONG_ADDR_TAG, cmd_i.loco_address[13:8]};
      addr_lo   = cmd_i.loco_address[7:0];
      func_op   = {OP_FUNC_ONE_TAG, cmd_i.function_bits};

      speed_sat = (cmd_i.speed_step == SPEED_OVER) ? SPEED_MAX : cmd_i.speed_step;
      if (cmd_i.emergency_stop) begin
         speed_code = SPEED_ESTOP;
      end else begin
         speed_code    = (speed_sat == 7'd0) ? 8'h00 : ({1'b0, speed_sat} + 8'd1);
         speed_code[7] = cmd_i.forward;
      end

      for (int i = 0; i < SLOT_COUNT; i++) begin
         cmd_byte[i] = 8'h00;
      end

      case (cmd_i.kind)
         KIND_FUNC_ONE: begin
            if (long_addr) begin
               cmd_byte[0] = addr_hi;
               cmd_byte[1] = addr_lo;
               cmd_byte[2] = func_op;
               cmd_count   = 3'd3;
            end else begin
               cmd_byte[0] = addr_lo;
               cmd_byte[1] = func_op;
               cmd_count   = 3'd2;
            end
         end
         KIND_THROTTLE: begin
            if (long_addr) begin
               cmd_byte[0] = addr_hi;
               cmd_byte[1] = addr_lo;
               cmd_byte[2] = OP_SPEED_128;
               cmd_byte[3] = speed_code;
               cmd_count   = 3'd4;
            end else begin
               cmd_byte[0] = addr_lo;
               cmd_byte[1] = OP_SPEED_128;
               cmd_byte[2] = speed_code;
               cmd_count   = 3'd3;
            end
         end
         default: begin
            // idle, and the unused kind code
            cmd_byte[0] = BYTE_IDLE_ADDR;
            cmd_byte[1] = BYTE_IDLE_DATA;
            cmd_count   = 3'd2;
         end
      endcase

      check = cmd_byte[0] ^ cmd_byte[1] ^ cmd_byte[2] ^ cmd_byte[3];

      // checksum goes straight after the command bytes, unused slots idle high
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (3'(i) == cmd_count) begin
            cmd_byte[i] = check;
         end
         slot[i] = (3'(i) <= cmd_count) ? {1'b0, cmd_byte[i]} : {SLOT_BITS{1'b1}};
      end

      frame_o.bits   = {{PREAMBLE_LEN{1'b1}}, slot[0], slot[1], slot[2], slot[3], slot[4],
                        {TAIL_LEN{1'b1}}};
      frame_o.nbytes = {1'b0, cmd_count} + 4'd5;
   end

endmodule

>>> design/dcc_packet_framer_core.sv
// top level of the dcc packet framer: request holding stage and byte shifter
// the first byte of a packet is offered once its request has passed the holding stage and loaded into the shifter
// packets are 7, 8 or 9 bytes long; the byte shifter offers one byte per cycle while the receiver is ready;
//   the next packet loads on the edge that hands off the last byte, so bytes stream gap-free
// a second request is held while a packet drains, so the request side stalls only when both
//   the holding stage and the shifter are busy
// reset: synchronous, active high; both stages empty afterwards
module dcc_packet_framer_core (
   input logic       clock,
   input logic       reset,
   dcc_req_if.sink   req_bus,
   dcc_rsp_if.source rsp_bus
);
   import dcc_pkg::*;

   // holding stage for one request
   logic    hold_valid_ff, hold_valid_in;
   req_type hold_data_ff,  hold_data_in;

   // byte shifter, top byte is the one on offer
   logic [STREAM_BITS-1:0] stream_ff, stream_in;
   logic [3:0]             left_ff,   left_in;

   frame_type frame;
   logic      req_take;
   logic      rsp_take;
   logic      shift_free;
   logic      load;

   dcc_frame_build u_build (
      .cmd_i   (hold_data_ff),
      .frame_o (frame)
   );

   // shifter is free when empty or when its last byte leaves this cycle
   assign rsp_take   = rsp_bus.valid && rsp_bus.ready;
   assign shift_free = (left_ff == 4'd0) || (rsp_take && rsp_bus.last_byte);
   assign load       = hold_valid_ff && shift_free;

   // holding stage takes a request when empty or when it hands on this cycle
   assign req_bus.ready = !hold_valid_ff || load;
   assign req_take      = req_bus.valid && req_bus.ready;

   assign rsp_bus.valid       = left_ff != 4'd0;
   assign rsp_bus.packet_byte = stream_ff[STREAM_BITS-1 -: 8];
   assign rsp_bus.last_byte   = left_ff == 4'd1;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_data_in  = hold_data_ff;
      if (load) begin
         hold_valid_in = 1'b0;
      end
      if (req_take) begin
         hold_valid_in               = 1'b1;
         hold_data_in.kind           = req_bus.kind;
         hold_data_in.loco_address   = req_bus.loco_address;
         hold_data_in.speed_step     = req_bus.speed_step;
         hold_data_in.forward        = req_bus.forward;
         hold_data_in.emergency_stop = req_bus.emergency_stop;
         hold_data_in.function_bits  = req_bus.function_bits;
      end
   end

   always_comb begin
      stream_in = stream_ff;
      left_in   = left_ff;
      if (load) begin
         stream_in = frame.bits;
         left_in   = frame.nbytes;
      end else if (rsp_take) begin
         stream_in = {stream_ff[STREAM_BITS-9:0], 8'h00};
         left_in   = left_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         left_ff       <= 4'd0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         left_ff       <= left_in;
      end
      hold_data_ff <= hold_data_in;
      stream_ff    <= stream_in;
   end

   // a freshly loaded packet is 7 to 9 bytes long
   a_load_len: assert property (@(posedge clock) disable iff (reset)
      load |=> (left_ff >= 4'd7) && (left_ff <= 4'(MAX_BYTES)))
      else $error("loaded packet length out of range");

   // every packet opens with a preamble byte that is not the last one
   a_load_preamble: assert property (@(posedge clock) disable iff (reset)
      load |=> (rsp_bus.packet_byte == 8'hFF) && !rsp_bus.last_byte)
      else $error("packet does not open with preamble");

   // with nothing held, the shifter goes empty after the last byte
   a_drain_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && rsp_bus.last_byte && !hold_valid_ff) |=> !rsp_bus.valid)
      else $error("shifter not empty after last byte");

   // a held request moves on as soon as the shifter is free
   a_no_bubble: assert property (@(posedge clock) disable iff (reset)
      (hold_valid_ff && shift_free) |=> rsp_bus.valid)
      else $error("held request did not load");

endmodule

>>> dv/tb.sv
// self-checking testbench for the dcc packet framer core
`timescale 1ns / 100ps

module tb;
   import dcc_pkg::*;

   // kind 3 is not a defined command; the framer treats it as idle
   localparam kind_type KIND_UNUSED = 2'd3;

   // generous bound on the whole run, several times the slowest correct run
   localparam int CYCLE_LIMIT   = 200000;
   localparam int RANDOM_COUNT  = 170;
   localparam int DRAIN_CYCLES  = 20;
   localparam int IDLE_PERCENT  = 37;

   typedef struct packed {
      logic [7:0] packet_byte;
      logic       last_byte;
   } frame_byte_type;

   logic clock;
   logic reset;

   dcc_req_if req_bus ();
   dcc_rsp_if rsp_bus ();

   dcc_packet_framer_core i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // stream bytes still owed by the framer, oldest first
   frame_byte_type expected_bytes[$];

   int unsigned    cycle_count;
   int unsigned    mismatch_count;
   int unsigned    request_count;
   int unsigned    bytes_checked;
   int unsigned    packets_checked;
   int unsigned    kind_count[4];
   int unsigned    long_addr_count;
   int unsigned    estop_count;
   bit             no_idle;
   frame_byte_type got_byte;
   frame_byte_type want_byte;

   // free-running clock, 10 ns period
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // frame predictor: command bytes, checksum, then the packed bit stream
   // ------------------------------------------------------------------

   // address in short or long form; returns the new command length
   function automatic int add_address(ref logic [7:0] cmd[6], input int n,
                                      input logic [13:0] addr);
      if (addr > SHORT_ADDR_MAX) begin
         cmd[n] = {LONG_ADDR_TAG, addr[13:8]};
         n++;
      end
      cmd[n] = addr[7:0];
      return n + 1;
   endfunction

   // queue up every stream byte that one accepted request should produce
   function automatic void predict_frame(input req_type cmd_in);
      logic [7:0]     cmd[6];
      logic [0:71]    stream;
      logic [6:0]     speed;
      logic [7:0]     speed_code;
      logic [7:0]     checksum;
      frame_byte_type fb;
      int             n;
      int             pos;
      int             nbytes;

      n = 0;
      case (cmd_in.kind)
         KIND_FUNC_ONE: begin
            n = add_address(cmd, n, cmd_in.loco_address);
            cmd[n] = {OP_FUNC_ONE_TAG, cmd_in.function_bits};
            n++;
         end
         KIND_THROTTLE: begin
            n = add_address(cmd, n, cmd_in.loco_address);
            cmd[n] = OP_SPEED_128;
            n++;
            if (cmd_in.emergency_stop) begin
               speed_code = SPEED_ESTOP;
            end else begin
               // over-range speed clamps to the top step
               speed = (cmd_in.speed_step > SPEED_MAX) ? SPEED_MAX : cmd_in.speed_step;
               speed_code = (speed == 7'd0) ? 8'h00 : {1'b0, speed + 7'd1};
               speed_code[7] = cmd_in.forward;
            end
            cmd[n] = speed_code;
            n++;
         end
         default: begin
            // idle, and the unused kind framed as idle
            cmd[0] = BYTE_IDLE_ADDR;
            cmd[1] = BYTE_IDLE_DATA;
            n = 2;
         end
      endcase

      checksum = 8'h00;
      for (int i = 0; i < n; i++) checksum ^= cmd[i];
      cmd[n] = checksum;
      n++;

      // start from all ones: preamble, stop bit and padding need no writes
      stream = '1;
      pos = PREAMBLE_LEN;
      for (int i = 0; i < n; i++) begin
         stream[pos] = 1'b0;
         for (int b = 7; b >= 0; b--) stream[pos + 8 - b] = cmd[i][b];
         pos += 9;
      end
      pos++;
      nbytes = (pos + 7) / 8;

      for (int i = 0; i < nbytes; i++) begin
         fb.packet_byte = stream[8*i +: 8];
         fb.last_byte   = (i == nbytes - 1);
         expected_bytes.push_back(fb);
      end
   endfunction

   // ------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------

   function automatic req_type make_request(kind_type kind, logic [13:0] addr,
                                            logic [6:0] speed, logic fwd,
                                            logic estop, logic [4:0] fbits);
      req_type r;
      r.kind           = kind;
      r.loco_address   = addr;
      r.speed_step     = speed;
      r.forward        = fwd;
      r.emergency_stop = estop;
      r.function_bits  = fbits;
      return r;
   endfunction

   // offer one request, with random idle cycles ahead of it; valid stays
   // high on return so back-to-back requests need no gap
   task automatic send_request(input req_type cmd);
      @(negedge clock);
      while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.kind           <= cmd.kind;
      req_bus.loco_address   <= cmd.loco_address;
      req_bus.speed_step     <= cmd.speed_step;
      req_bus.forward        <= cmd.forward;
      req_bus.emergency_stop <= cmd.emergency_stop;
      req_bus.function_bits  <= cmd.function_bits;
      req_bus.valid          <= 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      // request taken on this edge
      predict_frame(cmd);
      request_count++;
      kind_count[cmd.kind]++;
      if (cmd.loco_address > SHORT_ADDR_MAX && cmd.kind inside {KIND_FUNC_ONE, KIND_THROTTLE})
         long_addr_count++;
      if (cmd.emergency_stop && cmd.kind == KIND_THROTTLE) estop_count++;
   endtask

   // drop valid and hold off until the framer has delivered everything
   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_bytes.size() != 0) @(negedge clock);
   endtask

   // ------------------------------------------------------------------
   // result side: random back-pressure and the byte checker
   // ------------------------------------------------------------------

   always @(negedge clock) begin
      rsp_bus.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= IDLE_PERCENT);
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got_byte.packet_byte = rsp_bus.packet_byte;
         got_byte.last_byte   = rsp_bus.last_byte;
         if (expected_bytes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("error: unexpected byte %02h last %b at cycle %0d",
                        got_byte.packet_byte, got_byte.last_byte, cycle_count);
         end else begin
            want_byte = expected_bytes.pop_front();
            bytes_checked++;
            if (want_byte.last_byte) packets_checked++;
            if (got_byte !== want_byte) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("error: byte expected %02h last %b, got %02h last %b at cycle %0d",
                           want_byte.packet_byte, want_byte.last_byte,
                           got_byte.packet_byte, got_byte.last_byte, cycle_count);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("error: run timed out after %0d cycles, %0d bytes outstanding",
                  cycle_count, expected_bytes.size());
         $display("dcc_packet_framer_core test failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // test tasks
   // ------------------------------------------------------------------

   // idle packet, plus the unused kind which must frame identically
   task automatic test_idle_packets();
      send_request(make_request(KIND_IDLE, 14'd0, 7'd0, 1'b0, 1'b0, 5'd0));
      send_request(make_request(KIND_IDLE, 14'h3FFF, 7'h7F, 1'b1, 1'b1, 5'h1F));
      send_request(make_request(KIND_UNUSED, 14'h2AAA, 7'h55, 1'b1, 1'b0, 5'h0A));
   endtask

   // function group one over address boundaries and all-zero/all-one bits
   task automatic test_function_group();
      send_request(make_request(KIND_FUNC_ONE, 14'd0, 7'd0, 1'b0, 1'b0, 5'h00));
      send_request(make_request(KIND_FUNC_ONE, 14'd127, 7'h7F, 1'b1, 1'b1, 5'h1F));
      send_request(make_request(KIND_FUNC_ONE, 14'd128, 7'd0, 1'b0, 1'b0, 5'h15));
      send_request(make_request(KIND_FUNC_ONE, 14'h3FFF, 7'd3, 1'b0, 1'b0, 5'h0A));
   endtask

   // throttle: stop, lowest and highest step, saturation, both directions,
   // emergency stop, short and long addresses
   task automatic test_throttle();
      send_request(make_request(KIND_THROTTLE, 14'd3, 7'd0, 1'b0, 1'b0, 5'd0));
      send_request(make_request(KIND_THROTTLE, 14'd3, 7'd0, 1'b1, 1'b0, 5'd0));
      send_request(make_request(KIND_THROTTLE, 14'd1, 7'd1, 1'b1, 1'b0, 5'h1F));
      send_request(make_request(KIND_THROTTLE, 14'd127, 7'd126, 1'b1, 1'b0, 5'd0));
      send_request(make_request(KIND_THROTTLE, 14'd127, 7'd126, 1'b0, 1'b0, 5'd0));
      send_request(make_request(KIND_THROTTLE, 14'd128, 7'd127, 1'b1, 1'b0, 5'd0));
      send_request(make_request(KIND_THROTTLE, 14'd128, 7'd127, 1'b0, 1'b0, 5'd0));
      send_request(make_request(KIND_THROTTLE, 14'h3FFF, 7'd64, 1'b1, 1'b1, 5'd0));
      send_request(make_request(KIND_THROTTLE, 14'd0, 7'd127, 1'b0, 1'b1, 5'h1F));
      send_request(make_request(KIND_THROTTLE, 14'd0, 7'd42, 1'b1, 1'b0, 5'd0));
      send_request(make_request(KIND_THROTTLE, 14'h2000, 7'h2A, 1'b0, 1'b0, 5'd0));
   endtask

   function automatic logic [13:0] random_address();
      case ($urandom_range(4))
         0: return 14'($urandom_range(127));
         1: return 14'($urandom_range(16383, 128));
         2: begin
            case ($urandom_range(3))
               0: return 14'd0;
               1: return 14'd127;
               2: return 14'd128;
               default: return 14'h3FFF;
            endcase
         end
         default: return 14'($urandom_range(16383));
      endcase
   endfunction

   // random commands with one drain pause and one stretch with no idling
   task automatic test_random_commands();
      req_type  cmd;
      kind_type kind;
      for (int i = 0; i < RANDOM_COUNT; i++) begin
         // the sender pauses once until the framer is empty
         if (i == RANDOM_COUNT / 4) wait_drained();
         no_idle = (i >= 70 && i < 110);
         // the unused kind now and then, the three real commands otherwise
         kind = ($urandom_range(15) == 0) ? KIND_UNUSED : kind_type'($urandom_range(2));
         cmd = make_request(kind, random_address(), 7'($urandom_range(127)),
                            1'($urandom_range(1)), ($urandom_range(7) == 0),
                            5'($urandom_range(31)));
         send_request(cmd);
      end
      no_idle = 1'b0;
   endtask

   // ------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------

   initial begin
      reset                  = 1'b1;
      no_idle                = 1'b0;
      req_bus.valid          = 1'b0;
      req_bus.kind           = KIND_IDLE;
      req_bus.loco_address   = '0;
      req_bus.speed_step     = '0;
      req_bus.forward        = 1'b0;
      req_bus.emergency_stop = 1'b0;
      req_bus.function_bits  = '0;
      rsp_bus.ready          = 1'b0;
      cycle_count            = 0;
      mismatch_count         = 0;
      request_count          = 0;
      bytes_checked          = 0;
      packets_checked        = 0;
      long_addr_count        = 0;
      estop_count            = 0;
      for (int k = 0; k < 4; k++) kind_count[k] = 0;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_idle_packets();
      test_function_group();
      test_throttle();
      test_random_commands();

      // let the framer empty, then watch for stray bytes
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_bytes.size() != 0) begin
         mismatch_count++;
         $display("error: %0d expected bytes never arrived", expected_bytes.size());
      end

      $display("summary: %0d requests (idle %0d, function %0d, throttle %0d, unused kind %0d)",
               request_count, kind_count[KIND_IDLE], kind_count[KIND_FUNC_ONE],
               kind_count[KIND_THROTTLE], kind_count[KIND_UNUSED]);
      $display("summary: %0d packets, %0d bytes checked, %0d long addresses, %0d e-stops",
               packets_checked, bytes_checked, long_addr_count, estop_count);
      if (mismatch_count == 0) begin
         $display("dcc_packet_framer_core test passed");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("dcc_packet_framer_core test failed");
      end
      $finish;
   end

endmodule
